// ===== sv/thb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thb_pkg: shared types and constants of the timestamp history buffer
// Record layout, command and result words, and the back-end sequencer states.
// ----------------------------------------------------------------------------
package thb_pkg;

   localparam int DEPTH       = 128;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int STAMP_W     = 64;
   localparam int WORD_W      = 32;
   localparam int FUNC_W      = 2;
   localparam int HELD_W      = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int REC_W       = STAMP_W + 4 * WORD_W;
   localparam int REQ_TDATA_W = ((REC_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((REC_W + HELD_W + 7) / 8) * 8;

   localparam logic [FUNC_W-1:0] FUNC_PUSH    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NEAREST = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LATEST  = 2'd2;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_NEAREST,
      OP_LATEST,
      OP_IGNORE
   } op_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [WORD_W-1:0]  seq;
      logic [WORD_W-1:0]  pos_x;
      logic [WORD_W-1:0]  pos_y;
      logic [WORD_W-1:0]  pos_z;
   } rec_type;

   typedef struct packed {
      op_type  op;
      rec_type rec;
   } cmd_type;

   typedef struct packed {
      logic              found;
      rec_type           rec;
      logic [HELD_W-1:0] held_count;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LATEST
   } state_type;

endpackage

// ===== sv/timestamp_history_buffer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_history_buffer_unit: circular history of timestamped records
// Every request word gives one response word. A push stores the record in
// the next slot, overwriting the oldest once 128 records are held. A latest
// query issues a registered read of the record memory and loads the result
// in ST_LATEST. A nearest query walks the memory from oldest to newest at
// one record per cycle through its single read port, and stops early at the
// first record past the target that does not improve. A two-entry command
// queue lets requests be taken while a query runs. The store needs no
// clearing after reset: only written slots are ever read.
// ----------------------------------------------------------------------------
module timestamp_history_buffer_unit import thb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // stamp, seq_in, pos_x_in, pos_y_in, pos_z_in
   input  logic [FUNC_W-1:0]      req_tuser,  // func
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // stamp_out, seq_out, pos_x_out, pos_y_out,
                                              // pos_z_out, held_count
   output logic [0:0]             rsp_tuser   // found
);

   logic    f_valid, f_ready;
   cmd_type f_cmd;
   logic    q_valid, q_ready;
   cmd_type q_cmd;

   thb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd        (f_cmd)
   );

   thb_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_cmd    (f_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   thb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== sv/thb_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thb_front: request intake
// Accepts request words, unpacks the record fields and classifies the
// selector into a command for the back end.
// ----------------------------------------------------------------------------
module thb_front import thb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // stamp, seq, pos_x, pos_y, pos_z
   input  logic [FUNC_W-1:0]      req_tuser,  // func
   output logic                   cmd_valid,
   input  logic                   cmd_ready,
   output cmd_type                cmd
);

   logic unused_clk;

   assign unused_clk = clock ^ reset;
   assign req_tready = cmd_ready;
   assign cmd_valid  = req_tvalid;

   always_comb begin
      cmd.rec.stamp = req_tdata[STAMP_W-1:0];
      cmd.rec.seq   = req_tdata[STAMP_W +: WORD_W];
      cmd.rec.pos_x = req_tdata[STAMP_W + WORD_W +: WORD_W];
      cmd.rec.pos_y = req_tdata[STAMP_W + 2 * WORD_W +: WORD_W];
      cmd.rec.pos_z = req_tdata[STAMP_W + 3 * WORD_W +: WORD_W];
      case (req_tuser)
         FUNC_PUSH:    cmd.op = OP_PUSH;
         FUNC_NEAREST: cmd.op = OP_NEAREST;
         FUNC_LATEST:  cmd.op = OP_LATEST;
         default:      cmd.op = OP_IGNORE;
      endcase
   end

endmodule

// ===== sv/thb_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thb_cmd_queue: command queue
// Short FIFO between the intake and the back end so each side stalls alone.
// ----------------------------------------------------------------------------
module thb_cmd_queue import thb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);

   cmd_type            q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               push, pop;

   assign in_ready  = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_cmd   = q_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

// ===== sv/thb_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thb_back: record store and query engine
// Holds the circular record memory, runs pushes, latest reads and the
// oldest-to-newest nearest-timestamp scan, and drives the result register.
// ----------------------------------------------------------------------------
module thb_back import thb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   output logic                   cmd_ready,
   input  cmd_type                cmd,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // stamp, seq, pos_x, pos_y, pos_z, held_count
   output logic [0:0]             rsp_tuser   // found
);

   rec_type             mem [DEPTH];
   rec_type             rd_data_ff;
   logic                rd_en, mem_we;
   logic [IDX_W-1:0]    rd_addr;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    wr_slot_ff, wr_slot_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [IDX_W-1:0]    addr_ff, addr_in;
   logic [CNT_W-1:0]    issued_ff, issued_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic                first_ff, first_in;
   logic [STAMP_W-1:0]  target_ff, target_in;
   logic [STAMP_W-1:0]  min_ff, min_in;
   rec_type             best_ff, best_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff, out_in;

   logic                out_free;
   logic [CNT_W-1:0]    oldest_wide;
   logic [IDX_W-1:0]    latest_slot;
   logic [STAMP_W-1:0]  diff;
   logic                improve, stop;

   assign out_free    = !out_valid_ff || rsp_tready;
   assign oldest_wide = (CNT_W'(wr_slot_ff) >= total_ff)
                        ? CNT_W'(wr_slot_ff) - total_ff
                        : CNT_W'(wr_slot_ff) + CNT_W'(DEPTH) - total_ff;
   assign latest_slot = (wr_slot_ff == '0) ? IDX_W'(DEPTH - 1) : wr_slot_ff - 1'b1;
   assign diff        = (rd_data_ff.stamp >= target_ff) ? rd_data_ff.stamp - target_ff
                                                        : target_ff - rd_data_ff.stamp;
   assign improve     = (diff < min_ff);
   assign stop        = !improve && (rd_data_ff.stamp > target_ff);

   always_comb begin
      state_in     = state_ff;
      wr_slot_in   = wr_slot_ff;
      total_in     = total_ff;
      addr_in      = addr_ff;
      issued_in    = issued_ff;
      cmp_valid_in = 1'b0;
      first_in     = first_ff;
      target_in    = target_ff;
      min_in       = min_ff;
      best_in      = best_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_in       = out_ff;
      cmd_ready    = 1'b0;
      mem_we       = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = addr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready         = 1'b1;
               out_in            = '0;
               out_in.held_count = HELD_W'(total_ff);
               case (cmd.op)
                  OP_PUSH: begin
                     mem_we            = 1'b1;
                     wr_slot_in        = (wr_slot_ff == IDX_W'(DEPTH - 1))
                                         ? '0 : wr_slot_ff + 1'b1;
                     total_in          = (total_ff == CNT_W'(DEPTH))
                                         ? total_ff : total_ff + 1'b1;
                     out_in.held_count = HELD_W'(total_in);
                     out_valid_in      = 1'b1;
                  end
                  OP_NEAREST: begin
                     if (total_ff == '0) begin
                        out_valid_in = 1'b1;
                     end else begin
                        state_in  = ST_SCAN;
                        addr_in   = oldest_wide[IDX_W-1:0];
                        issued_in = '0;
                        first_in  = 1'b1;
                        target_in = cmd.rec.stamp;
                        min_in    = '1;
                     end
                  end
                  OP_LATEST: begin
                     if (total_ff == '0) begin
                        out_valid_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = latest_slot;
                        state_in = ST_LATEST;
                     end
                  end
                  default: begin
                     out_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_LATEST: begin
            out_in.found      = 1'b1;
            out_in.rec        = rd_data_ff;
            out_in.held_count = HELD_W'(total_ff);
            out_valid_in      = 1'b1;
            state_in          = ST_IDLE;
         end
         ST_SCAN: begin
            if (cmp_valid_ff) begin
               if (improve) begin
                  min_in = diff;
               end
               if (improve || first_ff) begin
                  best_in = rd_data_ff;
               end
               first_in = 1'b0;
            end
            if (cmp_valid_ff && (stop || issued_ff == total_ff)) begin
               out_in.found      = 1'b1;
               out_in.rec        = best_in;
               out_in.held_count = HELD_W'(total_ff);
               out_valid_in      = 1'b1;
               state_in          = ST_IDLE;
            end else if (issued_ff != total_ff) begin
               rd_en        = 1'b1;
               rd_addr      = addr_ff;
               addr_in      = (addr_ff == IDX_W'(DEPTH - 1)) ? '0 : addr_ff + 1'b1;
               issued_in    = issued_ff + 1'b1;
               cmp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_slot_ff   <= '0;
         total_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_slot_ff   <= wr_slot_in;
         total_ff     <= total_in;
         cmp_valid_ff <= cmp_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      issued_ff <= issued_in;
      first_ff  <= first_in;
      target_ff <= target_in;
      min_ff    <= min_in;
      best_ff   <= best_in;
      out_ff    <= out_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_slot_ff] <= cmd.rec;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tuser[0] = out_ff.found;
   assign rsp_tdata    = RSP_TDATA_W'({out_ff.held_count, out_ff.rec.pos_z,
                                       out_ff.rec.pos_y, out_ff.rec.pos_x,
                                       out_ff.rec.seq, out_ff.rec.stamp});

endmodule

// ===== sv/thb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thb_checker: port-level checks of the timestamp history buffer
// Watches the response channel of the top level; bound to it below.
// ----------------------------------------------------------------------------
module thb_checker import thb_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [0:0]             rsp_tuser
);

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[REC_W +: HELD_W] <= HELD_W'(DEPTH))
      else $error("held count beyond capacity");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[REC_W-1:0] == '0)
      else $error("record fields set without a hit");

   a_hit_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[REC_W +: HELD_W] != '0)
      else $error("hit reported from an empty store");

endmodule

bind timestamp_history_buffer_unit thb_checker u_thb_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== sim/thb_history_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thb_history_checker: response predictor and comparator
// Watches both streams of the timestamp history buffer. Every accepted request
// word is run through a behavioral copy of the record history (push, nearest
// and latest lookup) and the expected response word is queued. Every accepted
// response word is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module thb_history_checker import thb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [FUNC_W-1:0]      req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [0:0]             rsp_tuser,
   output int                     fail_count,
   output int                     pending_count,
   output int                     checked_count
);

   localparam int SEQ_LO  = STAMP_W;
   localparam int X_LO    = SEQ_LO + WORD_W;
   localparam int Y_LO    = X_LO + WORD_W;
   localparam int Z_LO    = Y_LO + WORD_W;
   localparam int HELD_LO = Z_LO + WORD_W;

   rec_type     hist_mem [DEPTH];
   int unsigned hist_wr    = 0;
   int unsigned hist_cnt   = 0;
   rsp_type     answer_q [$];
   rsp_type     want;
   rec_type     pushed;
   int          mismatches = 0;
   int          pending    = 0;
   int          checked    = 0;

   assign fail_count    = mismatches;
   assign pending_count = pending;
   assign checked_count = checked;

   function automatic rsp_type predict_answer(input logic [FUNC_W-1:0] fn,
                                              input rec_type item);
      rsp_type            ans;
      int unsigned        oldest;
      int unsigned        best;
      int unsigned        slot;
      int unsigned        k;
      logic [STAMP_W-1:0] ts;
      logic [STAMP_W-1:0] gap;
      logic [STAMP_W-1:0] min_gap;
      ans = '0;
      case (op_type'(fn))
         OP_PUSH: begin
            hist_mem[hist_wr] = item;
            hist_wr = (hist_wr + 1) % DEPTH;
            if (hist_cnt < DEPTH) hist_cnt++;
         end
         OP_NEAREST: if (hist_cnt != 0) begin
            // walk oldest to newest, keep first strict minimum, stop past target without improvement
            oldest  = (hist_wr + DEPTH - (hist_cnt % DEPTH)) % DEPTH;
            best    = oldest;
            min_gap = '1;
            for (k = 0; k < hist_cnt; k++) begin
               slot = (oldest + k) % DEPTH;
               ts   = hist_mem[slot].stamp;
               gap  = (ts >= item.stamp) ? ts - item.stamp : item.stamp - ts;
               if (gap < min_gap) begin
                  min_gap = gap;
                  best    = slot;
               end else if (ts > item.stamp) begin
                  break;
               end
            end
            ans.found = 1'b1;
            ans.rec   = hist_mem[best];
         end
         OP_LATEST: if (hist_cnt != 0) begin
            ans.found = 1'b1;
            ans.rec   = hist_mem[(hist_wr + DEPTH - 1) % DEPTH];
         end
         default: begin
         end
      endcase
      ans.held_count = hist_cnt[HELD_W-1:0];
      return ans;
   endfunction

   task automatic report_mismatch(input string what, input logic [STAMP_W-1:0] got,
                                  input logic [STAMP_W-1:0] exp_val);
      mismatches++;
      if (mismatches <= 40)
         $display("ERROR response word %0d, %s: got %h, expected %h",
                  checked, what, got, exp_val);
   endtask

   task automatic check_field(input string what, input logic [STAMP_W-1:0] got,
                              input logic [STAMP_W-1:0] exp_val);
      if (got !== exp_val) report_mismatch(what, got, exp_val);
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pushed.stamp = req_tdata[0 +: STAMP_W];
            pushed.seq   = req_tdata[SEQ_LO +: WORD_W];
            pushed.pos_x = req_tdata[X_LO +: WORD_W];
            pushed.pos_y = req_tdata[Y_LO +: WORD_W];
            pushed.pos_z = req_tdata[Z_LO +: WORD_W];
            answer_q.insert(answer_q.size(), predict_answer(req_tuser, pushed));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               report_mismatch("word with nothing expected", rsp_tdata[0 +: STAMP_W], '0);
            end else begin
               want = answer_q.pop_front();
               check_field("found", rsp_tuser, want.found);
               check_field("stamp_out", rsp_tdata[0 +: STAMP_W], want.rec.stamp);
               check_field("seq_out", rsp_tdata[SEQ_LO +: WORD_W], want.rec.seq);
               check_field("pos_x_out", rsp_tdata[X_LO +: WORD_W], want.rec.pos_x);
               check_field("pos_y_out", rsp_tdata[Y_LO +: WORD_W], want.rec.pos_y);
               check_field("pos_z_out", rsp_tdata[Z_LO +: WORD_W], want.rec.pos_z);
               check_field("held_count", rsp_tdata[HELD_LO +: HELD_W], want.held_count);
            end
            checked++;
         end
         pending = answer_q.size();
      end
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream testbench of the timestamp history buffer unit
// Drives a directed set of corner words (empty store, extreme stamps, ties,
// no-improvement scans, unused selector) and then a random mix of pushes with
// mostly rising stamps and nearest/latest queries aimed around the held range.
// Both sides idle at random, with a calm window and a long response hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import thb_pkg::*;

   localparam int RANDOM_WORDS = 1880;
   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 300;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [FUNC_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [0:0]             rsp_tuser;

   int   fail_count;
   int   pending_count;
   int   checked_count;
   logic sender_calm  = 1'b0;
   int   quiet_cycles = 0;
   int   sink_cycle   = 0;
   int   push_words   = 0;
   int   nearest_words = 0;
   int   latest_words = 0;
   int   ignored_words = 0;

   always #10 clock = ~clock;

   timestamp_history_buffer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   thb_history_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   function automatic logic [STAMP_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic rec_type rec_of(input logic [STAMP_W-1:0] stamp,
                                      input logic [WORD_W-1:0] seq,
                                      input logic [WORD_W-1:0] x,
                                      input logic [WORD_W-1:0] y,
                                      input logic [WORD_W-1:0] z);
      rec_type r;
      r.stamp = stamp;
      r.seq   = seq;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_word(input op_type op, input rec_type item);
      while (!sender_calm && $urandom_range(0, 99) < 38) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {item.pos_z, item.pos_y, item.pos_x, item.seq, item.stamp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      case (op)
         OP_PUSH:    push_words++;
         OP_NEAREST: nearest_words++;
         OP_LATEST:  latest_words++;
         default:    ignored_words++;
      endcase
      @(negedge clock);
   endtask

   // response side: random stalls, one long hold-off, one calm window
   initial begin
      wait (!reset);
      forever begin
         @(negedge clock);
         sink_cycle++;
         if (sink_cycle >= 1500 && sink_cycle < 1900) begin
            rsp_tready = 1'b0;
         end else if (sink_cycle >= 5000 && sink_cycle < 8000) begin
            rsp_tready = 1'b1;
         end else begin
            rsp_tready = ($urandom_range(0, 99) >= 38);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
               $display("Test completed with failures");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      logic [STAMP_W-1:0] stamp_base;
      logic [STAMP_W-1:0] stamp;
      logic [WORD_W-1:0]  seq_next;
      int                 pick;
      int                 roll;
      int                 n;
      stamp_base = rand64() >> 8;
      seq_next   = $urandom;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty store, extremes, ties, no-improvement and early-stop scans
      send_word(OP_NEAREST, rec_of('0, '0, '0, '0, '0));
      send_word(OP_LATEST, rec_of('1, '1, '1, '1, '1));
      send_word(OP_IGNORE, rec_of('1, '1, '1, '1, '1));
      send_word(OP_PUSH, rec_of('0, '0, '0, '0, '0));
      send_word(OP_NEAREST, rec_of('1, '0, '0, '0, '0));
      send_word(OP_PUSH, rec_of('0, 32'h1, 32'h3f80_0000, 32'hbf80_0000, 32'h7f80_0000));
      send_word(OP_NEAREST, rec_of('1, '1, '1, '1, '1));
      send_word(OP_PUSH, rec_of('1, '1, '1, '1, '1));
      send_word(OP_NEAREST, rec_of('0, '0, '0, '0, '0));
      send_word(OP_NEAREST, rec_of('1, '0, '0, '0, '0));
      send_word(OP_LATEST, rec_of('0, '0, '0, '0, '0));
      send_word(OP_IGNORE, rec_of(64'h5555_aaaa_5555_aaaa, '1, '0, '1, '0));
      send_word(OP_PUSH, rec_of(64'd1000, 32'h10, 32'haaaa_aaaa, 32'h5555_5555, 32'h0));
      send_word(OP_PUSH, rec_of(64'd2000, 32'h11, 32'h1, 32'h2, 32'h3));
      send_word(OP_PUSH, rec_of(64'd2000, 32'h12, 32'h4, 32'h5, 32'h6));
      send_word(OP_NEAREST, rec_of(64'd1990, '0, '0, '0, '0));
      send_word(OP_NEAREST, rec_of(64'hffff_ffff_ffff_fffe, '0, '0, '0, '0));
      send_word(OP_NEAREST, rec_of(64'h8000_0000_0000_0000, '0, '0, '0, '0));
      send_word(OP_LATEST, rec_of('0, '0, '0, '0, '0));
      send_word(OP_IGNORE, rec_of('0, '0, '0, '0, '0));

      for (n = 0; n < RANDOM_WORDS; n++) begin
         sender_calm = (n >= 700 && n < 1000);
         pick = $urandom_range(0, 99);
         roll = $urandom_range(0, 99);
         if (pick < 50) begin
            if (roll < 5) stamp_base = rand64();
            if (roll >= 5 && roll < 8) begin
               stamp = roll[0] ? '1 : '0;
            end else begin
               stamp_base = stamp_base + $urandom_range(0, 1500);
               stamp = stamp_base;
            end
            if ($urandom_range(0, 9) == 0) seq_next = $urandom;
            send_word(OP_PUSH, rec_of(stamp, seq_next, $urandom, $urandom, $urandom));
            seq_next++;
         end else if (pick < 85) begin
            if (roll < 65) begin
               stamp = stamp_base - $urandom_range(0, 100000) + $urandom_range(0, 2000);
            end else if (roll < 80) begin
               stamp = rand64();
            end else if (roll < 92) begin
               stamp = stamp_base;
            end else begin
               stamp = roll[0] ? '1 : '0;
            end
            send_word(OP_NEAREST, rec_of(stamp, $urandom, $urandom, $urandom, $urandom));
         end else if (pick < 95) begin
            send_word(OP_LATEST, rec_of(rand64(), $urandom, $urandom, $urandom, $urandom));
         end else begin
            send_word(OP_IGNORE, rec_of(rand64(), $urandom, $urandom, $urandom, $urandom));
         end
      end
      sender_calm = 1'b0;
      req_tvalid  = 1'b0;

      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d words: %0d pushes, %0d nearest, %0d latest, %0d unused selector",
               push_words + nearest_words + latest_words + ignored_words,
               push_words, nearest_words, latest_words, ignored_words);
      $display("Compared %0d response words against the predicted record history",
               checked_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
